// ===== design/sfs_pkg.sv =====
// Shared types and constants for the slim/fat frequency sketch engine.
package sfs_pkg;

  localparam int CMD_W   = 2;
  localparam int IDX_W   = 12;
  localparam int DELTA_W = 16;
  localparam int EST_W   = 16;
  localparam int CFG_W   = 5;
  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  typedef enum logic [CMD_W-1:0] {
    CMD_INC   = 2'd0,
    CMD_DEC   = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_RSVD  = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_REDUCE,
    S_INC_RD,
    S_INC_ADD,
    S_INC_MIN,
    S_INC_UPD,
    S_DEC_RD,
    S_DEC_ACC,
    S_DEC_UPD,
    S_Q_RD,
    S_Q_MIN
  } state_e;

endpackage

// ===== design/sfs_in_if.sv =====
// Input channel of the sketch engine: command, per-row fat indices and delta.
interface sfs_in_if import sfs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [IDX_W-1:0]   fat_index_0;
  logic [IDX_W-1:0]   fat_index_1;
  logic [IDX_W-1:0]   fat_index_2;
  logic [IDX_W-1:0]   fat_index_3;
  logic [DELTA_W-1:0] delta;

  modport source (output valid, command, fat_index_0, fat_index_1, fat_index_2,
                  fat_index_3, delta, input ready);
  modport sink   (input valid, command, fat_index_0, fat_index_1, fat_index_2,
                  fat_index_3, delta, output ready);
endinterface

// ===== design/sfs_out_if.sv =====
// Output channel of the sketch engine: the query estimate.
interface sfs_out_if import sfs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [EST_W-1:0] estimate;

  modport source (output valid, estimate, input ready);
  modport sink   (input valid, estimate, output ready);
endinterface

// ===== design/slim_fat_sketch_engine.sv =====
// Top level of the slim/fat frequency sketch engine.
// Each row owns a fat and a slim counter memory; all rows work in parallel under one
// sequencer. After reset the block sweeps both memories to zero before it takes its
// first beat. Every increment, decrement or query beat first reduces the fat index
// to slim column and group by repeated subtraction of SLIM_WIDTH, one step a cycle.
// Then an increment reads, adds, takes the row minima and updates the slim counters;
// a query reads the slim counters and takes their minimum, plus any wait for the
// previous estimate to be taken; a decrement does one memory read per fat counter of
// the slim column, then updates the slim counter. Unknown commands are accepted and
// dropped.
module slim_fat_sketch_engine import sfs_pkg::*; #(
  parameter int ROWS         = 4,
  parameter int SLIM_WIDTH   = 1024,
  parameter int FAT_FACTOR   = 4,
  parameter int COUNTER_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  sfs_in_if.sink           in_i,
  sfs_out_if.source        out_o
);

  localparam int FAT_WIDTH = SLIM_WIDTH * FAT_FACTOR;
  localparam int FAW  = $clog2(FAT_WIDTH);
  localparam int CW   = $clog2(SLIM_WIDTH);
  localparam int GW   = $clog2(FAT_FACTOR);
  localparam int LW   = COUNTER_BITS;
  localparam int SW   = ((LW > DELTA_W) ? LW : DELTA_W) + 1;
  localparam int SUMW = LW + 4;

  state_e state_q, state_d;

  logic [CFG_W-1:0]   cb_q;
  logic [CMD_W-1:0]   cmd_q;
  logic [DELTA_W-1:0] delta_q;
  logic [FAW-1:0]     clr_q;
  logic [GW-1:0]      i_q;
  logic [LW-1:0]      minr_q, minl_q;
  logic               out_valid_q;
  logic [EST_W-1:0]   est_q;

  logic [IDX_W-1:0]   r_q    [ROWS];
  logic [GW-1:0]      grp_q  [ROWS];
  logic [LW-1:0]      c_q    [ROWS];
  logic [LW-1:0]      slv_q  [ROWS];
  logic [SUMW-1:0]    sum_q  [ROWS];

  logic [LW-1:0]      fat_rd_q  [ROWS];
  logic [LW-1:0]      slim_rd_q [ROWS];
  logic               fat_we    [ROWS];
  logic               fat_re;
  logic [FAW-1:0]     fat_wa    [ROWS];
  logic [FAW-1:0]     fat_ra    [ROWS];
  logic [LW-1:0]      fat_wd    [ROWS];
  logic               slim_we   [ROWS];
  logic               slim_re;
  logic [CW-1:0]      slim_wa   [ROWS];
  logic [LW-1:0]      slim_wd   [ROWS];

  logic [CW-1:0]      col       [ROWS];
  logic [FAW-1:0]     grp_addr  [ROWS];
  logic [FAW-1:0]     i_addr    [ROWS];
  logic [LW-1:0]      sat_sum   [ROWS];
  logic [LW-1:0]      dec_val   [ROWS];
  logic [IDX_W-1:0]   in_idx    [4];

  logic [LW-1:0]      lim;
  logic [5:0]         eff_bits;
  logic [32:0]        lim_w;
  logic               reduce_done;
  logic               clr_last;
  logic               i_last;
  logic               in_acc;
  logic               q_go;
  logic [LW-1:0]      minr, minl, minq;
  logic [SW-1:0]      tgt_w;
  logic [LW-1:0]      tgt;

  // Saturation limit from the counter width register
  always_comb begin
    eff_bits = ({1'b0, cb_q} > 6'(COUNTER_BITS)) ? 6'(COUNTER_BITS) : {1'b0, cb_q};
    lim_w    = (33'd1 << eff_bits) - 33'd1;
    lim      = lim_w[LW-1:0];
  end

  assign in_idx[0] = in_i.fat_index_0;
  assign in_idx[1] = in_i.fat_index_1;
  assign in_idx[2] = in_i.fat_index_2;
  assign in_idx[3] = in_i.fat_index_3;

  assign in_i.ready     = (state_q == S_IDLE);
  assign in_acc         = in_i.valid && in_i.ready;
  assign out_o.valid    = out_valid_q;
  assign out_o.estimate = est_q;
  assign clr_last       = (clr_q == FAW'(FAT_WIDTH - 1));
  assign i_last         = (i_q == GW'(FAT_FACTOR - 1));
  assign q_go           = !out_valid_q || out_o.ready;

  // Per-row address and arithmetic
  always_comb begin
    reduce_done = 1'b1;
    for (int d = 0; d < ROWS; d++) begin
      if (32'(r_q[d]) >= 32'(SLIM_WIDTH)) reduce_done = 1'b0;
      col[d]      = CW'(r_q[d]);
      grp_addr[d] = FAW'(FAW'(grp_q[d]) * FAW'(SLIM_WIDTH)) + FAW'(col[d]);
      i_addr[d]   = FAW'(FAW'(i_q) * FAW'(SLIM_WIDTH)) + FAW'(col[d]);
      sat_sum[d]  = ((SW'(fat_rd_q[d]) + SW'(delta_q)) > SW'(lim)) ? lim :
                    LW'(SW'(fat_rd_q[d]) + SW'(delta_q));
      dec_val[d]  = (SW'(fat_rd_q[d]) > SW'(delta_q)) ?
                    LW'(SW'(fat_rd_q[d]) - SW'(delta_q)) : '0;
    end
  end

  // Minima over rows
  always_comb begin
    minr = lim;
    minl = lim;
    minq = lim;
    for (int d = 0; d < ROWS; d++) begin
      if (c_q[d] < minr) minr = c_q[d];
      if (slv_q[d] < minl) minl = slv_q[d];
      if (slim_rd_q[d] < minq) minq = slim_rd_q[d];
    end
    tgt_w = SW'(minl_q) + SW'(delta_q);
    tgt   = (tgt_w >= SW'(minr_q)) ? minr_q : LW'(tgt_w);
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR:   if (clr_last) state_d = S_IDLE;
      S_IDLE: begin
        if (in_acc && (in_i.command == CMD_INC || in_i.command == CMD_DEC ||
                       in_i.command == CMD_QUERY)) begin
          state_d = S_REDUCE;
        end
      end
      S_REDUCE: begin
        if (reduce_done) begin
          case (cmd_q)
            CMD_INC: state_d = S_INC_RD;
            CMD_DEC: state_d = S_DEC_RD;
            default: state_d = S_Q_RD;
          endcase
        end
      end
      S_INC_RD:  state_d = S_INC_ADD;
      S_INC_ADD: state_d = S_INC_MIN;
      S_INC_MIN: state_d = S_INC_UPD;
      S_INC_UPD: state_d = S_IDLE;
      S_DEC_RD:  state_d = S_DEC_ACC;
      S_DEC_ACC: state_d = i_last ? S_DEC_UPD : S_DEC_RD;
      S_DEC_UPD: state_d = S_IDLE;
      S_Q_RD:    state_d = S_Q_MIN;
      S_Q_MIN:   if (q_go) state_d = S_IDLE;
      default:   state_d = S_CLEAR;
    endcase
  end

  // Memory controls
  always_comb begin
    fat_re  = (state_q == S_INC_RD) || (state_q == S_DEC_RD);
    slim_re = (state_q == S_INC_RD) || (state_q == S_DEC_RD) || (state_q == S_Q_RD);
    for (int d = 0; d < ROWS; d++) begin
      fat_we[d]  = 1'b0;
      fat_wa[d]  = grp_addr[d];
      fat_wd[d]  = sat_sum[d];
      fat_ra[d]  = (state_q == S_DEC_RD) ? i_addr[d] : grp_addr[d];
      slim_we[d] = 1'b0;
      slim_wa[d] = col[d];
      slim_wd[d] = tgt;
      case (state_q)
        S_CLEAR: begin
          fat_we[d]  = 1'b1;
          fat_wa[d]  = clr_q;
          fat_wd[d]  = '0;
          slim_we[d] = (32'(clr_q) < 32'(SLIM_WIDTH));
          slim_wa[d] = CW'(clr_q);
          slim_wd[d] = '0;
        end
        S_INC_ADD: fat_we[d] = 1'b1;
        S_INC_UPD: slim_we[d] = (minl_q < minr_q) && (slv_q[d] < tgt);
        S_DEC_ACC: begin
          fat_we[d] = (i_q == grp_q[d]);
          fat_wa[d] = i_addr[d];
          fat_wd[d] = dec_val[d];
        end
        S_DEC_UPD: begin
          slim_we[d] = (SUMW'(slim_rd_q[d]) > sum_q[d]);
          slim_wd[d] = LW'(sum_q[d]);
        end
        default: ;
      endcase
    end
  end

  // Row memories
  for (genvar g = 0; g < ROWS; g++) begin : g_row
    logic [LW-1:0] fat_mem  [FAT_WIDTH];
    logic [LW-1:0] slim_mem [SLIM_WIDTH];

    always_ff @(posedge clk_i) begin
      if (fat_we[g]) fat_mem[fat_wa[g]] <= fat_wd[g];
      if (fat_re) fat_rd_q[g] <= fat_mem[fat_ra[g]];
    end

    always_ff @(posedge clk_i) begin
      if (slim_we[g]) slim_mem[slim_wa[g]] <= slim_wd[g];
      if (slim_re) slim_rd_q[g] <= slim_mem[col[g]];
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      cb_q        <= CFG_RESET;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) cb_q <= cfg_wdata_i;
      if (state_q == S_CLEAR) clr_q <= clr_q + FAW'(1);
      if (state_q == S_Q_MIN && q_go) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        cmd_q   <= in_i.command;
        delta_q <= in_i.delta;
        for (int d = 0; d < ROWS; d++) begin
          r_q[d]   <= in_idx[d % 4];
          grp_q[d] <= '0;
        end
      end
      S_REDUCE: begin
        i_q <= '0;
        for (int d = 0; d < ROWS; d++) begin
          sum_q[d] <= '0;
          if (32'(r_q[d]) >= 32'(SLIM_WIDTH)) begin
            r_q[d]   <= r_q[d] - IDX_W'(SLIM_WIDTH);
            grp_q[d] <= (grp_q[d] == GW'(FAT_FACTOR - 1)) ? '0 : grp_q[d] + GW'(1);
          end
        end
      end
      S_INC_ADD: begin
        for (int d = 0; d < ROWS; d++) begin
          c_q[d]   <= sat_sum[d];
          slv_q[d] <= slim_rd_q[d];
        end
      end
      S_INC_MIN: begin
        minr_q <= minr;
        minl_q <= minl;
      end
      S_DEC_ACC: begin
        i_q <= i_q + GW'(1);
        for (int d = 0; d < ROWS; d++) begin
          sum_q[d] <= sum_q[d] + SUMW'((i_q == grp_q[d]) ? dec_val[d] : fat_rd_q[d]);
        end
      end
      S_Q_MIN: if (q_go) est_q <= EST_W'(minq);
      default: ;
    endcase
  end

endmodule

// ===== bench/tb_slim_fat_sketch_engine.sv =====
// Self-checking bench for the slim/fat sketch engine: directed table, then random traffic.
`timescale 1ns / 1ps

module tb_slim_fat_sketch_engine;
  import sfs_pkg::*;

  localparam int ROWS = 4;
  localparam int SLIM_W = 1024;
  localparam int FAT_F = 4;
  localparam int FAT_W = SLIM_W * FAT_F;
  localparam int CBITS = 16;
  localparam int N_RANDOM = 1100;
  localparam int SETTLE = 40;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [IDX_W-1:0]   idx0;
    logic [IDX_W-1:0]   idx1;
    logic [IDX_W-1:0]   idx2;
    logic [IDX_W-1:0]   idx3;
    logic [DELTA_W-1:0] delta;
  } beat_t;

  // One directed row: the beat, and an optional typed-in estimate
  typedef struct {
    beat_t            b;
    bit               known;
    logic [EST_W-1:0] est;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_W-1:0] cfg_wdata_i = CFG_RESET;

  sfs_in_if  in_ch ();
  sfs_out_if out_ch ();

  slim_fat_sketch_engine u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_i(in_ch.sink), .out_o(out_ch.source)
  );

  always #5 clk_i = ~clk_i;

  // Predictor state
  logic [31:0] fat_mem [ROWS][FAT_W];
  logic [31:0] slim_mem [ROWS][SLIM_W];
  logic [CFG_W-1:0] bits_reg = CFG_RESET;
  logic [EST_W-1:0] est_queue [$];
  int errors = 0;
  bit stim_done = 1'b0;

  function automatic longint sat_limit();
    int b;
    b = (bits_reg > CBITS) ? CBITS : int'(bits_reg);
    return (longint'(1) << b) - 1;
  endfunction

  function automatic int col_of(beat_t b, int d);
    logic [IDX_W-1:0] ix;
    case (d % 4)
      0: ix = b.idx0;
      1: ix = b.idx1;
      2: ix = b.idx2;
      default: ix = b.idx3;
    endcase
    return int'(ix) % FAT_W;
  endfunction

  // Advance the predicted sketch by one beat; push the estimate for a query
  task automatic sketch_apply(beat_t b);
    longint lim, minr, minl, tgt, c, sum, dl;
    int f, col, grp, idx;
    int cols [ROWS];
    longint sv [ROWS];
    lim = sat_limit();
    dl = b.delta;
    case (b.command)
      CMD_INC: begin
        minr = lim;
        minl = lim;
        for (int d = 0; d < ROWS; d++) begin
          f = col_of(b, d);
          c = fat_mem[d][f] + dl;
          if (c > lim) c = lim;
          fat_mem[d][f] = c[31:0];
          if (c < minr) minr = c;
          cols[d] = f % SLIM_W;
        end
        for (int d = 0; d < ROWS; d++) begin
          sv[d] = slim_mem[d][cols[d]];
          if (sv[d] < minl) minl = sv[d];
        end
        if (minl < minr) begin
          tgt = (minl + dl >= minr) ? minr : minl + dl;
          for (int d = 0; d < ROWS; d++)
            if (sv[d] < tgt) slim_mem[d][cols[d]] = tgt[31:0];
        end
      end
      CMD_DEC: begin
        for (int d = 0; d < ROWS; d++) begin
          f = col_of(b, d);
          grp = f / SLIM_W;
          col = f % SLIM_W;
          sum = 0;
          for (int i = 0; i < FAT_F; i++) begin
            idx = SLIM_W * i + col;
            c = fat_mem[d][idx];
            if (i == grp) begin
              c = (c > dl) ? c - dl : 0;
              fat_mem[d][idx] = c[31:0];
            end
            sum += c;
          end
          if (slim_mem[d][col] > sum) slim_mem[d][col] = sum[31:0];
        end
      end
      CMD_QUERY: begin
        minr = lim;
        for (int d = 0; d < ROWS; d++) begin
          c = slim_mem[d][col_of(b, d) % SLIM_W];
          if (c < minr) minr = c;
        end
        est_queue.push_back(minr[EST_W-1:0]);
      end
      default: ;
    endcase
  endtask

  // Drive one beat after a random gap and hold it until accepted
  task automatic send_beat(beat_t b);
    int gap;
    gap = $urandom_range(0, 10);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    {in_ch.command, in_ch.fat_index_0, in_ch.fat_index_1, in_ch.fat_index_2,
     in_ch.fat_index_3, in_ch.delta} <= b;
    do @(posedge clk_i); while (!in_ch.ready);
    sketch_apply(b);
  endtask

  // Wait for all estimates, then let the last update drain before a register write
  task automatic write_bits(logic [CFG_W-1:0] v);
    in_ch.valid <= 1'b0;
    while (est_queue.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    bits_reg = v;
  endtask

  function automatic beat_t make_beat(cmd_e cmd, int i0, int i1, int i2, int i3, int dl);
    beat_t b;
    b.command = cmd;
    b.idx0 = IDX_W'(i0);
    b.idx1 = IDX_W'(i1);
    b.idx2 = IDX_W'(i2);
    b.idx3 = IDX_W'(i3);
    b.delta = DELTA_W'(dl);
    return b;
  endfunction

  // Random beat over a small key pool so keys revisit counters and columns collide
  function automatic beat_t rand_beat();
    beat_t b;
    int key, sel;
    key = $urandom_range(0, 15);
    b.idx0 = IDX_W'(($urandom_range(0, 3) << 10) | (key * 37 % SLIM_W));
    b.idx1 = IDX_W'(($urandom_range(0, 3) << 10) | (key * 91 % SLIM_W));
    b.idx2 = (key < 8) ? IDX_W'(key * 512) : IDX_W'(key * 3);
    b.idx3 = ($urandom_range(0, 7) == 0) ? IDX_W'($urandom) : IDX_W'(4095 - key);
    sel = $urandom_range(0, 99);
    if (sel < 45) b.command = CMD_INC;
    else if (sel < 70) b.command = CMD_DEC;
    else if (sel < 97) b.command = CMD_QUERY;
    else b.command = CMD_RSVD;
    case ($urandom_range(0, 3))
      0: b.delta = DELTA_W'($urandom_range(0, 3));
      1: b.delta = DELTA_W'($urandom_range(0, 200));
      2: b.delta = DELTA_W'($urandom);
      default: b.delta = 16'hFFFF;
    endcase
    return b;
  endfunction

  // Receiver: random stalls, compare each estimate against the oldest expectation
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
      if (est_queue.size() == 0) begin
        $error("estimate beat with nothing expected: actual %0d", out_ch.estimate);
        errors++;
      end else begin
        logic [EST_W-1:0] want;
        want = est_queue.pop_front();
        if (out_ch.estimate !== want) begin
          $error("estimate mismatch: expected %0d, actual %0d", want, out_ch.estimate);
          errors++;
        end
      end
    end
  end

  // Stimulus
  initial begin
    row_t dir [$];
    row_t r;
    logic [CFG_W-1:0] cfg_plan [6];
    in_ch.valid = 1'b0;
    {in_ch.command, in_ch.fat_index_0, in_ch.fat_index_1, in_ch.fat_index_2,
     in_ch.fat_index_3, in_ch.delta} = '0;
    for (int d = 0; d < ROWS; d++) begin
      for (int i = 0; i < FAT_W; i++) fat_mem[d][i] = 0;
      for (int i = 0; i < SLIM_W; i++) slim_mem[d][i] = 0;
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed table: known estimates only where obvious
    r.known = 1; r.est = 0; r.b = make_beat(CMD_QUERY, 0, 0, 0, 0, 16'hFFFF); dir.push_back(r);
    r.known = 0; r.b = make_beat(CMD_INC, 0, 0, 0, 0, 16'hFFFF); dir.push_back(r);
    r.known = 1; r.est = 16'hFFFF; r.b = make_beat(CMD_QUERY, 0, 0, 0, 0, 0); dir.push_back(r);
    r.known = 0; r.b = make_beat(CMD_INC, 0, 0, 0, 0, 16'hFFFF); dir.push_back(r);
    r.known = 1; r.est = 16'hFFFF; r.b = make_beat(CMD_QUERY, 0, 0, 0, 0, 0); dir.push_back(r);
    r.known = 0; r.b = make_beat(CMD_INC, 4095, 4095, 4095, 4095, 5); dir.push_back(r);
    r.b = make_beat(CMD_INC, 1023, 2047, 3071, 4095, 7); dir.push_back(r);
    r.b = make_beat(CMD_QUERY, 4095, 4095, 4095, 4095, 0); dir.push_back(r);
    r.b = make_beat(CMD_DEC, 3071, 3071, 3071, 3071, 3); dir.push_back(r);
    r.b = make_beat(CMD_QUERY, 1023, 1023, 1023, 1023, 0); dir.push_back(r);
    r.b = make_beat(CMD_DEC, 4095, 4095, 4095, 4095, 16'hFFFF); dir.push_back(r);
    r.b = make_beat(CMD_QUERY, 4095, 4095, 4095, 4095, 0); dir.push_back(r);
    r.b = make_beat(CMD_RSVD, 0, 0, 0, 0, 16'hFFFF); dir.push_back(r);
    r.b = make_beat(CMD_INC, 2730, 1365, 2730, 1365, 16'hAAAA); dir.push_back(r);
    r.b = make_beat(CMD_INC, 1365, 2730, 1365, 2730, 16'h5555); dir.push_back(r);
    r.b = make_beat(CMD_QUERY, 2730, 1365, 2730, 1365, 0); dir.push_back(r);
    r.b = make_beat(CMD_DEC, 0, 0, 0, 0, 0); dir.push_back(r);
    r.b = make_beat(CMD_QUERY, 0, 0, 0, 0, 16'hFFFF); dir.push_back(r);
    foreach (dir[i]) begin
      if (dir[i].known) begin
        logic [EST_W-1:0] p;
        send_beat(dir[i].b);
        p = est_queue[$];
        if (p !== dir[i].est) begin
          $error("estimate table row %0d: expected %0d, predicted %0d", i, dir[i].est, p);
          errors++;
        end
      end else begin
        send_beat(dir[i].b);
      end
    end

    // Random phases across counter widths, extremes included
    cfg_plan = '{5'd4, 5'd0, 5'd31, 5'd1, 5'd16, 5'd9};
    foreach (cfg_plan[p]) begin
      write_bits(cfg_plan[p]);
      for (int n = 0; n < N_RANDOM / 6; n++) send_beat(rand_beat());
    end
    in_ch.valid <= 1'b0;
    stim_done = 1'b1;
  end

  // End of run
  initial begin
    wait (stim_done);
    while (est_queue.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    #5ms;
    $display("simulation failed");
    $finish;
  end

endmodule
